### hdl/spmc_pkg.sv
// Package for the stream pattern match counter.
// Holds payload structs, the window link type and register index codes.
// No dependencies.
`default_nettype none

package spmc_pkg;

  // Width of the pattern storage, fixed by the register map.
  localparam int PAT_BYTES = 32;
  localparam int LEN_W     = 6;
  localparam int COUNT_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_3 = 3'd4;

  typedef logic [PAT_BYTES-1:0][7:0] pat_bytes_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_t;

  typedef struct packed {
    logic               match_here;
    logic [COUNT_W-1:0] match_count;
    logic [COUNT_W-1:0] byte_count;
    logic               stream_done;
  } out_t;

  // One window entry handed from cell to cell.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } link_t;

  // Compare result handed from the window to the counter stage.
  typedef struct packed {
    logic hit;
    logic eof;
  } cmp_t;

endpackage

`default_nettype wire

### hdl/spmc_cell.sv
// One window cell: holds one stream byte and its valid bit, compares it.
// Depends on spmc_pkg.
`default_nettype none

module spmc_cell
  import spmc_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             shift_en,
  input  wire logic             clear,
  input  wire link_t            link_in,
  output link_t                 link_out,
  input  wire pat_bytes_t       pattern,
  input  wire logic [LEN_W-1:0] len_eff,
  output logic                  match_ok
);

  localparam logic [LEN_W-1:0] IDX_L = LEN_W'(IDX);

  logic             valid_r, valid_nxt;
  logic [7:0]       data_r, data_nxt;
  logic             in_use;
  logic [LEN_W-1:0] sel;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (shift_en) begin
      valid_nxt = clear ? 1'b0 : link_in.valid;
      data_nxt  = link_in.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign link_out = '{valid: valid_r, data: data_r};

  // The entry this cell will hold after the shift is compared against the
  // pattern byte counted from the end of the pattern.
  assign in_use   = IDX_L < len_eff;
  assign sel      = len_eff - IDX_L - LEN_W'(1);
  assign match_ok = !in_use ||
                    (link_in.valid && (link_in.data == pattern[sel[LEN_W-2:0]]));

endmodule

`default_nettype wire

### hdl/spmc_tally.sv
// Counter stage: saturating match and byte counters and the result register.
// Depends on spmc_pkg.
`default_nettype none

module spmc_tally
  import spmc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic load,
  input  wire cmp_t cmp,
  output out_t      result
);

  logic [COUNT_W-1:0] matches_r, matches_nxt;
  logic [COUNT_W-1:0] bytes_r, bytes_nxt;
  logic [COUNT_W-1:0] match_sum, byte_sum;
  out_t               result_r, result_nxt;

  always_comb begin
    match_sum = matches_r;
    if (cmp.hit && (matches_r != '1)) begin
      match_sum = matches_r + COUNT_W'(1);
    end
    byte_sum = bytes_r;
    if (bytes_r != '1) begin
      byte_sum = bytes_r + COUNT_W'(1);
    end

    matches_nxt = matches_r;
    bytes_nxt   = bytes_r;
    result_nxt  = result_r;
    if (load) begin
      result_nxt = '{match_here: cmp.hit, match_count: match_sum,
                     byte_count: byte_sum, stream_done: cmp.eof};
      // The end of a stream starts the next one from zero.
      matches_nxt = cmp.eof ? '0 : match_sum;
      bytes_nxt   = cmp.eof ? '0 : byte_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matches_r <= '0;
      bytes_r   <= '0;
    end else begin
      matches_r <= matches_nxt;
      bytes_r   <= bytes_nxt;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

  assign result = result_r;

endmodule

`default_nettype wire

### hdl/stream_pattern_match_counter.sv
// Stream pattern match counter: the compare result of an accepted byte is
// registered in stage one, then tallied into the result register. Throughput
// is one byte per cycle while out_ready is high, set by the window cell chain
// shift and the two-register result pipeline. Reset (rst_n, synchronous,
// active low) empties the window, zeroes both counters, drops all pipeline
// valids and sets the pattern length to one with an all-zero pattern.
`default_nettype none

module stream_pattern_match_counter
  import spmc_pkg::*;
#(
  parameter int MAX_PATTERN = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_t                       out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

  // Configuration registers. The pattern words are kept as a byte array;
  // pattern byte 0 sits in the low byte of the first word.
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [3:0][CFG_DATA_W-1:0] words_r, words_nxt;
  pat_bytes_t            pattern;
  logic [LEN_W-1:0]      len_eff;

  always_comb begin
    len_nxt   = len_r;
    words_nxt = words_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_LENGTH: len_nxt      = cfg_wdata[LEN_W-1:0];
        REG_PATTERN_WORD_0: words_nxt[0] = cfg_wdata;
        REG_PATTERN_WORD_1: words_nxt[1] = cfg_wdata;
        REG_PATTERN_WORD_2: words_nxt[2] = cfg_wdata;
        REG_PATTERN_WORD_3: words_nxt[3] = cfg_wdata;
        default: begin
          // Writes to unmapped indexes are dropped.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= LEN_W'(1);
      words_r <= '0;
    end else begin
      len_r   <= len_nxt;
      words_r <= words_nxt;
    end
  end

  assign pattern = pat_bytes_t'(words_r);

  // A length beyond the window depth is treated as the full window depth.
  assign len_eff = (len_r > MAX_LEN) ? MAX_LEN : len_r;

  // Pipeline control. Stage one holds the compare result of an accepted
  // byte; the tally stage holds the finished result until its transfer.
  logic s1_valid_r, s1_valid_nxt;
  cmp_t s1_r, s1_nxt;
  logic out_valid_r, out_valid_nxt;
  logic tally_load;
  logic in_fire;

  assign tally_load = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready   = !s1_valid_r || tally_load;
  assign in_fire    = in_valid && in_ready;

  // The window is a chain of cells. The newest byte enters at cell zero
  // and every accepted byte moves each entry one cell further along.
  // Each cell checks the entry it is about to hold against its pattern byte.
  link_t [MAX_PATTERN:0]  link;
  logic [MAX_PATTERN-1:0] cell_ok;
  logic                   hit;

  assign link[0] = '{valid: 1'b1, data: in_data.data_byte};

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    spmc_cell #(
      .IDX(k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (in_fire),
      .clear    (in_data.end_of_file),
      .link_in  (link[k]),
      .link_out (link[k+1]),
      .pattern  (pattern),
      .len_eff  (len_eff),
      .match_ok (cell_ok[k])
    );
  end

  // A zero length never matches. An occurrence needs every cell in use to
  // hold a valid byte equal to its pattern byte.
  assign hit = (len_eff != '0) && (&cell_ok);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_nxt       = s1_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
      s1_nxt       = '{hit: hit, eof: in_data.end_of_file};
    end else if (tally_load) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (tally_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  // Saturating counters and the result register; the counters restart
  // after the end-of-file byte is tallied.
  spmc_tally u_tally (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (tally_load),
    .cmp    (s1_r),
    .result (out_data)
  );

  assign out_valid = out_valid_r;

  // A stalled compare result must stay in place until the tally takes it.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !tally_load) |=> (s1_valid_r && $stable(s1_r)))
    else $error("compare stage lost or changed a stalled result");

  // After an end-of-file transfer the window holds no valid entry.
  a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.end_of_file) |=> !link[1].valid)
    else $error("window not cleared after end of file");

  // Every result counts at least the byte it answers.
  a_byte_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data.byte_count != '0))
    else $error("result carries a zero byte count");

  // A match in this byte means the match count is not zero.
  a_match_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data.match_here) |-> (out_data.match_count != '0))
    else $error("match flagged with zero match count");

endmodule

`default_nettype wire
